/* src/assert_macros.svh */
// Assertion macros used by the top level to check the design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

`endif

/* src/frca_pkg.sv */
// Shared types and constants for the four-register checked ALU.
`timescale 1ns / 1ps

package frca_pkg;

    localparam int DATA_W   = 32;
    localparam int LEN_W    = 17;
    localparam int PC_OUT_W = 16;
    localparam int KIND_W   = 3;
    localparam int IDX_W    = 2;
    localparam int NUM_REGS = 4;
    localparam int DIV_CNT_W = 5;

    // Instruction kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_MOV = 3'd0,
        KIND_ADD = 3'd1,
        KIND_SUB = 3'd2,
        KIND_MUL = 3'd3,
        KIND_DIV = 3'd4,
        KIND_INC = 3'd5,
        KIND_DEC = 3'd6,
        KIND_JNZ = 3'd7
    } t_kind;

    // Completion status codes.
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_DIV_ZERO   = 3'd1,
        ST_OVERFLOW   = 3'd2,
        ST_NEG_TARGET = 3'd3,
        ST_RANGE      = 3'd4,
        ST_NOT_TAKEN  = 3'd5
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic div_step;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_run;
        logic div_last;
    } t_stat;

endpackage

/* src/frca_datapath.sv */
// Datapath: register file, program counter, operand latches, multiplier and divider.
`timescale 1ns / 1ps

module frca_datapath #(
    parameter int PC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  frca_pkg::t_cmd                      i_cmd,
    output frca_pkg::t_stat                     o_stat,
    input  logic                                i_cfg_we,
    input  logic [frca_pkg::LEN_W-1:0]          i_cfg_data,
    input  logic [frca_pkg::KIND_W-1:0]         i_kind,
    input  logic [frca_pkg::IDX_W-1:0]          i_dest_reg,
    input  logic                                i_src_is_reg,
    input  logic [frca_pkg::IDX_W-1:0]          i_src_reg,
    input  logic signed [frca_pkg::DATA_W-1:0]  i_immediate,
    output logic [2:0]                          o_status,
    output logic signed [frca_pkg::DATA_W-1:0]  o_reg_a,
    output logic signed [frca_pkg::DATA_W-1:0]  o_reg_b,
    output logic signed [frca_pkg::DATA_W-1:0]  o_reg_c,
    output logic signed [frca_pkg::DATA_W-1:0]  o_reg_d,
    output logic [frca_pkg::PC_OUT_W-1:0]       o_program_counter
);
    import frca_pkg::*;

    // Architectural state and configuration.
    logic signed [DATA_W-1:0] r_regs [NUM_REGS];
    logic [PC_BITS-1:0]       r_pc;
    logic [LEN_W-1:0]         r_prog_len;

    // Operands of the transaction in flight.
    t_kind                    r_kind;
    logic [IDX_W-1:0]         r_dst;
    logic signed [DATA_W-1:0] r_a;
    logic signed [DATA_W-1:0] r_b;
    logic [DATA_W-1:0]        r_imm;

    // Multiplier and divider state.
    logic signed [2*DATA_W-1:0] r_prod;
    logic [DATA_W-1:0]          r_quo;
    logic [DATA_W-1:0]          r_rem;
    logic [DATA_W-1:0]          r_dvs;
    logic [DIV_CNT_W-1:0]       r_cnt;
    logic                       r_neg;

    // Result snapshot.
    logic [2:0]               r_out_status;
    logic signed [DATA_W-1:0] r_out_regs [NUM_REGS];
    logic [PC_OUT_W-1:0]      r_out_pc;

    logic signed [DATA_W-1:0] n_b;
    logic [DATA_W-1:0]        a_mag;
    logic [DATA_W-1:0]        b_mag;
    logic [DATA_W:0]          rem_sh;
    logic [DATA_W+1:0]        trial;
    logic [DATA_W:0]          sum;
    logic [DATA_W:0]          diff;
    logic [DATA_W-1:0]        quo_res;
    t_status                  n_status;
    logic                     n_wr;
    logic signed [DATA_W-1:0] n_res;
    logic                     n_pc_load;
    logic [PC_BITS-1:0]       n_pc;
    logic signed [DATA_W-1:0] n_view [NUM_REGS];

    // Second operand: constant step for increment and decrement, else register or immediate.
    always_comb begin
        case (t_kind'(i_kind))
            KIND_INC: n_b = DATA_W'(1);
            KIND_DEC: n_b = '1;
            default:  n_b = i_src_is_reg ? r_regs[i_src_reg] : i_immediate;
        endcase
    end

    // Magnitudes for the unsigned divider.
    assign a_mag = r_a[DATA_W-1] ? DATA_W'(-r_a) : DATA_W'(r_a);
    assign b_mag = r_b[DATA_W-1] ? DATA_W'(-r_b) : DATA_W'(r_b);

    // One restoring division step.
    assign rem_sh = {r_rem, r_quo[DATA_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, r_dvs};

    assign o_stat.div_run  = (r_kind == KIND_DIV) && (r_b != '0);
    assign o_stat.div_last = &r_cnt;

    // Adder, subtractor and quotient sign fixup used at commit.
    assign sum     = {r_a[DATA_W-1], r_a} + {r_b[DATA_W-1], r_b};
    assign diff    = {r_a[DATA_W-1], r_a} - {r_b[DATA_W-1], r_b};
    assign quo_res = r_neg ? DATA_W'(-r_quo) : r_quo;

    // Result and status of the transaction.
    always_comb begin
        n_status  = ST_OK;
        n_wr      = 1'b0;
        n_res     = r_b;
        n_pc_load = 1'b0;
        case (r_kind) inside
            KIND_MOV: begin
                n_wr = 1'b1;
            end
            KIND_ADD, KIND_INC, KIND_DEC: begin
                n_res = sum[DATA_W-1:0];
                if (sum[DATA_W] != sum[DATA_W-1]) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    n_wr = 1'b1;
                end
            end
            KIND_SUB: begin
                n_res = diff[DATA_W-1:0];
                if (diff[DATA_W] != diff[DATA_W-1]) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    n_wr = 1'b1;
                end
            end
            KIND_MUL: begin
                n_res = r_prod[DATA_W-1:0];
                if ((r_prod[2*DATA_W-1:DATA_W-1] == '0) ||
                    (&r_prod[2*DATA_W-1:DATA_W-1])) begin
                    n_wr = 1'b1;
                end else begin
                    n_status = ST_OVERFLOW;
                end
            end
            KIND_DIV: begin
                n_res = quo_res;
                if (r_b == '0) begin
                    n_status = ST_DIV_ZERO;
                end else if (!r_neg && r_quo[DATA_W-1]) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    n_wr = 1'b1;
                end
            end
            KIND_JNZ: begin
                if (r_imm[DATA_W-1]) begin
                    n_status = ST_NEG_TARGET;
                end else if (r_regs[2] == '0) begin
                    n_status = ST_NOT_TAKEN;
                end else if (r_imm >= DATA_W'(r_prog_len)) begin
                    n_status = ST_RANGE;
                end else begin
                    n_pc_load = 1'b1;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Register values and program counter after this transaction.
    always_comb begin
        for (int i = 0; i < NUM_REGS; i++) begin
            n_view[i] = (n_wr && (r_dst == IDX_W'(i))) ? n_res : r_regs[i];
        end
        n_pc = n_pc_load ? r_imm[PC_BITS-1:0] : r_pc;
    end

    // Architectural state and configuration, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
            r_pc       <= '0;
            r_prog_len <= '0;
        end else begin
            if (i_cfg_we) begin
                r_prog_len <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                for (int i = 0; i < NUM_REGS; i++) begin
                    r_regs[i] <= n_view[i];
                end
                r_pc <= n_pc;
            end
        end
    end

    // Operand latches, multiplier, divider and result snapshot.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= t_kind'(i_kind);
            r_dst  <= i_dest_reg;
            r_a    <= r_regs[i_dest_reg];
            r_b    <= n_b;
            r_imm  <= i_immediate;
        end
        if (i_cmd.exec) begin
            r_prod <= r_a * r_b;
            r_quo  <= a_mag;
            r_rem  <= '0;
            r_dvs  <= b_mag;
            r_cnt  <= '0;
            r_neg  <= r_a[DATA_W-1] ^ r_b[DATA_W-1];
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
            if (!trial[DATA_W+1]) begin
                r_rem <= trial[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
        if (i_cmd.commit) begin
            r_out_status <= n_status;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_out_regs[i] <= n_view[i];
            end
            r_out_pc <= PC_OUT_W'(n_pc);
        end
    end

    assign o_status          = r_out_status;
    assign o_reg_a           = r_out_regs[0];
    assign o_reg_b           = r_out_regs[1];
    assign o_reg_c           = r_out_regs[2];
    assign o_reg_d           = r_out_regs[3];
    assign o_program_counter = r_out_pc;

endmodule

/* src/frca_ctrl.sv */
// Controller: sequences load, execute, divide and commit for one transaction at a time.
`timescale 1ns / 1ps

module frca_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  frca_pkg::t_stat i_stat,
    output frca_pkg::t_cmd  o_cmd
);
    import frca_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_COMMIT
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    // Commands decoded from the current state.
    always_comb begin
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec     = (r_state == S_EXEC);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.commit   = (r_state == S_COMMIT) && (!r_out_valid || i_out_ready);
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // State register and result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= i_stat.div_run ? S_DIV : S_COMMIT;
                end
                S_DIV: begin
                    if (i_stat.div_last) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    if (o_cmd.commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

/* src/four_register_checked_alu.sv */
// A result is registered at commit, which follows the execute state and, for a
// division, the divide state; commit waits while the output register still holds
// a result that has not been taken. One transaction at a time; the next is
// accepted the cycle after commit. The divider produces one quotient bit per cycle.
// Reset (synchronous, active low) clears all four registers, the program counter,
// the program length and the control state.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module four_register_checked_alu #(
    parameter int PC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [2:0]          i_kind,
    input  logic [1:0]          i_dest_reg,
    input  logic                i_src_is_reg,
    input  logic [1:0]          i_src_reg,
    input  logic signed [31:0]  i_immediate,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [2:0]          o_status,
    output logic signed [31:0]  o_reg_a,
    output logic signed [31:0]  o_reg_b,
    output logic signed [31:0]  o_reg_c,
    output logic signed [31:0]  o_reg_d,
    output logic [15:0]         o_program_counter,
    input  logic                i_cfg_we,
    input  logic [16:0]         i_cfg_data
);
    import frca_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Controller.
    frca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Datapath.
    frca_datapath #(
        .PC_BITS (PC_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_kind            (i_kind),
        .i_dest_reg        (i_dest_reg),
        .i_src_is_reg      (i_src_is_reg),
        .i_src_reg         (i_src_reg),
        .i_immediate       (i_immediate),
        .o_status          (o_status),
        .o_reg_a           (o_reg_a),
        .o_reg_b           (o_reg_b),
        .o_reg_c           (o_reg_c),
        .o_reg_d           (o_reg_d),
        .o_program_counter (o_program_counter)
    );

    // The block is busy in the cycle after it accepts a transaction.
    `ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "ready after accept")
    // A commit never overwrites a result that has not been taken.
    `ASSERT_IMPL(a_no_overwrite, cmd.commit, !o_out_valid || i_out_ready, "result overwritten")
    // A commit always presents a result in the next cycle.
    `ASSERT_NEXT(a_commit_valid, cmd.commit, o_out_valid, "commit without result")
    // At most one datapath command is active in any cycle.
    `ASSERT_ALWAYS(a_one_cmd, $onehot0(cmd), "overlapping datapath commands")

endmodule
